// ===== hdl/poc_pkg.sv =====
// ----------------------------------------------------------------------------
// poc_pkg
// Shared types and constants for the packing overlap checker.
// ----------------------------------------------------------------------------
package poc_pkg;

   localparam int MAX_RECTS_DEFAULT = 256;
   localparam int CSR_INDEX_WIDTH   = 2;
   localparam int CSR_DATA_WIDTH    = 15;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STRIP_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STRIP_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PATTERN_ONLY = 2'd2;

   typedef struct packed {
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic [14:0]        rect_width;
      logic [14:0]        rect_length;
      logic               last_rect;
   } req_type;

   typedef struct packed {
      logic [7:0] item_number;
      logic       in_bounds;
      logic       overlaps_earlier;
      logic [7:0] first_clash;
      logic       store_overflow;
      logic       layout_ok;
      logic       end_of_layout;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic [14:0]        rect_width;
      logic [14:0]        rect_length;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

// ===== hdl/packing_overlap_checker.sv =====
// ----------------------------------------------------------------------------
// packing_overlap_checker
// Checks a strip-packing layout one rectangle per transaction.
// ----------------------------------------------------------------------------
// Each request transaction carries one placed rectangle. The block checks it
// against the strip height and, unless pattern-only mode is set, against the
// strip width and the earlier rectangles of the layout held in the store,
// then returns one response transaction. The store has one read port, and one
// overlap comparator reads one stored rectangle per cycle. The scan stops on
// the first clash. Nothing is compared for the first rectangle of a layout,
// in pattern-only mode, or when the store is full. After the scan the response
// is loaded into the output register. The block takes no request from
// acceptance until the response is loaded and is ready again in the cycle
// after. A response waiting in the output register does not stall the next
// request, but holds that request's response until the register frees. The
// item that has last_rect set closes the layout.
// ----------------------------------------------------------------------------
module packing_overlap_checker
   import poc_pkg::*;
#(
   parameter int MAX_RECTS = MAX_RECTS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  req_type                    req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rsp_type                    rsp_data,
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wr_data
);

   localparam int CW = $clog2(MAX_RECTS + 1);
   localparam int IW = $clog2(MAX_RECTS);

   function automatic logic signed [16:0] span_end(logic signed [15:0] p,
                                                   logic [14:0] s);
      return {p[15], p} + $signed({2'b00, s});
   endfunction

   function automatic logic signed [16:0] widen(logic signed [15:0] p);
      return {p[15], p};
   endfunction

   state_type state_ff, state_in;

   logic [14:0] strip_width_ff, strip_height_ff;
   logic        pattern_only_ff;

   logic [CW-1:0] count_ff, count_in;
   logic          all_passed_ff, all_passed_in;
   logic          overflowed_ff, overflowed_in;

   req_type       cur_ff, cur_in;
   logic [CW-1:0] scan_end_ff, scan_end_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic          rd_valid_ff, rd_valid_in;
   logic [IW-1:0] rd_idx_ff, rd_idx_in;
   logic          clash_ff, clash_in;
   logic [IW-1:0] clash_idx_ff, clash_idx_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic      accept, full, issue, hit, load_rsp, separated, ok_bounds;
   entry_type wr_entry, rd_entry;

   // store and shared comparator
   assign wr_entry = '{pos_x: req_data.pos_x, pos_y: req_data.pos_y,
                       rect_width: req_data.rect_width,
                       rect_length: req_data.rect_length};

   poc_store #(
      .DEPTH (MAX_RECTS),
      .AW    (IW)
   ) u_store (
      .clock   (clock),
      .wr_en   (accept && !full),
      .wr_addr (count_ff[IW-1:0]),
      .wr_data (wr_entry),
      .rd_en   (issue),
      .rd_addr (ptr_ff[IW-1:0]),
      .rd_data (rd_entry)
   );

   assign full   = (count_ff == CW'(MAX_RECTS));
   assign accept = req_valid && req_ready;

   assign separated =
      (span_end(cur_ff.pos_x, cur_ff.rect_width) <= widen(rd_entry.pos_x)) ||
      (span_end(rd_entry.pos_x, rd_entry.rect_width) <= widen(cur_ff.pos_x)) ||
      (span_end(cur_ff.pos_y, cur_ff.rect_length) <= widen(rd_entry.pos_y)) ||
      (span_end(rd_entry.pos_y, rd_entry.rect_length) <= widen(cur_ff.pos_y));

   assign hit = (state_ff == ST_SCAN) && rd_valid_ff && !separated;

   always_comb begin
      ok_bounds = !cur_ff.pos_y[15] &&
                  (span_end(cur_ff.pos_y, cur_ff.rect_length) <=
                   $signed({2'b00, strip_height_ff}));
      if (!pattern_only_ff) begin
         ok_bounds = ok_bounds && !cur_ff.pos_x[15] &&
                     (span_end(cur_ff.pos_x, cur_ff.rect_width) <=
                      $signed({2'b00, strip_width_ff}));
      end
   end

   // sequencer: next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (hit || (ptr_ff >= scan_end_ff && !rd_valid_ff)) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (load_rsp) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer: outputs
   always_comb begin
      req_ready = 1'b0;
      issue     = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_SCAN:   issue     = (ptr_ff < scan_end_ff) && !hit;
         ST_FINISH: load_rsp  = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   // datapath
   always_comb begin
      cur_in       = accept ? req_data : cur_ff;
      scan_end_in  = scan_end_ff;
      ptr_in       = ptr_ff;
      clash_in     = clash_ff;
      clash_idx_in = clash_idx_ff;
      rd_valid_in  = issue;
      rd_idx_in    = ptr_ff[IW-1:0];
      if (accept) begin
         scan_end_in = (pattern_only_ff || full) ? '0 : count_ff;
         ptr_in      = '0;
         clash_in    = 1'b0;
      end else if (issue) begin
         ptr_in = ptr_ff + CW'(1);
      end
      if (hit) begin
         clash_in     = 1'b1;
         clash_idx_in = rd_idx_ff;
      end
   end

   // layout state and response
   always_comb begin
      count_in      = count_ff;
      all_passed_in = all_passed_ff;
      overflowed_in = overflowed_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_ready ? 1'b0 : rsp_valid_ff;
      if (load_rsp) begin
         rsp_in.item_number      = 8'(count_ff);
         rsp_in.in_bounds        = ok_bounds;
         rsp_in.overlaps_earlier = clash_ff;
         rsp_in.first_clash      = clash_ff ? 8'(clash_idx_ff) : 8'd0;
         rsp_in.store_overflow   = overflowed_ff || full;
         rsp_in.layout_ok        = all_passed_ff && ok_bounds && !clash_ff;
         rsp_in.end_of_layout    = cur_ff.last_rect;
         rsp_valid_in            = 1'b1;
         if (cur_ff.last_rect) begin
            count_in      = '0;
            all_passed_in = 1'b1;
            overflowed_in = 1'b0;
         end else begin
            count_in      = full ? count_ff : count_ff + CW'(1);
            all_passed_in = rsp_in.layout_ok;
            overflowed_in = rsp_in.store_overflow;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         count_ff        <= '0;
         all_passed_ff   <= 1'b1;
         overflowed_ff   <= 1'b0;
         rd_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         strip_width_ff  <= 15'd1;
         strip_height_ff <= 15'd0;
         pattern_only_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         all_passed_ff <= all_passed_in;
         overflowed_ff <= overflowed_in;
         rd_valid_ff   <= rd_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_STRIP_WIDTH:  strip_width_ff  <= csr_wr_data;
               CSR_STRIP_HEIGHT: strip_height_ff <= csr_wr_data;
               CSR_PATTERN_ONLY: pattern_only_ff <= csr_wr_data[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      scan_end_ff  <= scan_end_in;
      ptr_ff       <= ptr_in;
      rd_idx_ff    <= rd_idx_in;
      clash_ff     <= clash_in;
      clash_idx_ff <= clash_idx_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== hdl/poc_store.sv =====
// ----------------------------------------------------------------------------
// poc_store
// Rectangle store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module poc_store
   import poc_pkg::*;
#(
   parameter int DEPTH = MAX_RECTS_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  entry_type     wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output entry_type     rd_data
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== test/packing_overlap_checker_tb.sv =====
// ----------------------------------------------------------------------------
// packing_overlap_checker_tb
// Self-checking regression for the packing overlap checker.
// ----------------------------------------------------------------------------
// Rectangles are sent as request transactions. A shadow model of the strip
// limits, the rectangle store and the cumulative layout flags predicts each
// response transaction, which is compared field by field with the response.
// Directed tests cover reset values, the strip limits, edge contact and
// overlap scanning, pattern-only mode and store overflow. Random layouts
// then run under several strip settings, with bursty requests, stalling
// responses and one long response hold-off.
// ----------------------------------------------------------------------------
module packing_overlap_checker_tb;
   import poc_pkg::*;

   localparam int STORE_DEPTH      = MAX_RECTS_DEFAULT;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int MAX_SEND_GAP     = 12;
   localparam int WATCHDOG_LIMIT   =
      4 * (LONG_HOLD_CYCLES + STORE_DEPTH + 3 + MAX_SEND_GAP + 16);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED_INDEX = 2'd3;

   typedef enum int {
      RSP_ALWAYS,
      RSP_RANDOM,
      RSP_PERIODIC,
      RSP_SPARSE
   } rsp_pattern_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   req_type                    req_data = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b1;
   rsp_type                    rsp_data;
   logic                       csr_wr_en = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wr_data = '0;

   // shadow copy of the configuration and the layout state
   int cfg_width   = 1;
   int cfg_height  = 0;
   bit cfg_pattern = 1'b0;
   int shadow_x [STORE_DEPTH];
   int shadow_y [STORE_DEPTH];
   int shadow_w [STORE_DEPTH];
   int shadow_l [STORE_DEPTH];
   int stored_count   = 0;
   bit layout_clean   = 1'b1;
   bit layout_overrun = 1'b0;

   rsp_type         expected_verdicts[$];
   rsp_type         oldest_verdict;
   int              mismatch_count = 0;
   int              quiet_cycles;
   int              burst_left = 1;
   bit              gaps_on = 1'b1;
   bit              long_hold_armed = 1'b0;
   rsp_pattern_type rsp_pattern = RSP_ALWAYS;
   int              stall_tick = 0;

   packing_overlap_checker uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #10 clock = ~clock;

   function automatic rsp_type predict_verdict(req_type r);
      rsp_type v;
      int      x, y, w, l, j, clash_at;
      bit      fits, clash;
      x = $signed(r.pos_x);
      y = $signed(r.pos_y);
      w = r.rect_width;
      l = r.rect_length;
      clash = 1'b0;
      clash_at = 0;
      v.item_number = 8'(stored_count);
      fits = !(y < 0 || y + l > cfg_height);
      if (!cfg_pattern && (x < 0 || x + w > cfg_width)) fits = 1'b0;
      if (stored_count >= STORE_DEPTH) begin
         layout_overrun = 1'b1;
      end else begin
         if (!cfg_pattern) begin
            for (j = 0; j < stored_count && !clash; j++) begin
               if (!(x + w <= shadow_x[j] || shadow_x[j] + shadow_w[j] <= x ||
                     y + l <= shadow_y[j] || shadow_y[j] + shadow_l[j] <= y)) begin
                  clash = 1'b1;
                  clash_at = j;
               end
            end
         end
         shadow_x[stored_count] = x;
         shadow_y[stored_count] = y;
         shadow_w[stored_count] = w;
         shadow_l[stored_count] = l;
         stored_count++;
      end
      if (!fits || clash) layout_clean = 1'b0;
      v.in_bounds        = fits;
      v.overlaps_earlier = clash;
      v.first_clash      = 8'(clash_at);
      v.store_overflow   = layout_overrun;
      v.layout_ok        = layout_clean;
      v.end_of_layout    = r.last_rect;
      if (r.last_rect) begin
         stored_count   = 0;
         layout_clean   = 1'b1;
         layout_overrun = 1'b0;
      end
      return v;
   endfunction

   function automatic req_type random_rect(bit last);
      req_type r;
      int      x, y, w, l, pick;
      pick = $urandom_range(0, 99);
      w = $urandom_range(0, cfg_width / 4);
      l = $urandom_range(0, cfg_height / 4);
      x = $urandom_range(0, cfg_width - w);
      y = $urandom_range(0, cfg_height - l);
      if (pick < 12) begin
         r.pos_x       = 16'($urandom);
         r.pos_y       = 16'($urandom);
         r.rect_width  = 15'($urandom);
         r.rect_length = 15'($urandom);
      end else begin
         if (pick < 18) x = cfg_width - w + 1;
         else if (pick < 22) x = -1;
         else if (pick < 26) y = -1;
         else if (pick < 30) y = cfg_height - l + 1;
         r.pos_x       = 16'(x);
         r.pos_y       = 16'(y);
         r.rect_width  = 15'(w);
         r.rect_length = 15'(l);
      end
      r.last_rect = last;
      return r;
   endfunction

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_verdicts.size() == 0) begin
            $error("unexpected response transaction, item_number %0d",
                   rsp_data.item_number);
            mismatch_count++;
         end else begin
            oldest_verdict = expected_verdicts.pop_front();
            check_field("item_number", oldest_verdict.item_number,
                        rsp_data.item_number);
            check_field("in_bounds", oldest_verdict.in_bounds, rsp_data.in_bounds);
            check_field("overlaps_earlier", oldest_verdict.overlaps_earlier,
                        rsp_data.overlaps_earlier);
            check_field("first_clash", oldest_verdict.first_clash,
                        rsp_data.first_clash);
            check_field("store_overflow", oldest_verdict.store_overflow,
                        rsp_data.store_overflow);
            check_field("layout_ok", oldest_verdict.layout_ok, rsp_data.layout_ok);
            check_field("end_of_layout", oldest_verdict.end_of_layout,
                        rsp_data.end_of_layout);
         end
      end
   end

   // response side stall pattern
   initial begin
      forever begin
         @(negedge clock);
         stall_tick++;
         if (long_hold_armed) begin
            long_hold_armed = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
         end else begin
            case (rsp_pattern)
               RSP_ALWAYS:   rsp_ready <= 1'b1;
               RSP_RANDOM:   rsp_ready <= ($urandom_range(0, 3) != 0);
               RSP_PERIODIC: rsp_ready <= ((stall_tick % 7) < 4);
               default:      rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("packing_overlap_checker regression: fail");
      $finish;
   end

   task automatic send_rect(req_type r);
      req_data  <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_verdicts.push_back(predict_verdict(r));
      @(negedge clock);
   endtask

   task automatic send_fields(int x, int y, int w, int l, bit last);
      req_type r;
      r.pos_x       = 16'(x);
      r.pos_y       = 16'(y);
      r.rect_width  = 15'(w);
      r.rect_length = 15'(l);
      r.last_rect   = last;
      send_rect(r);
   endtask

   task automatic pause_sender(int cycles);
      if (cycles > 0) begin
         if (req_valid) req_valid <= 1'b0;
         repeat (cycles) @(negedge clock);
      end
   endtask

   task automatic send_paced(req_type r);
      send_rect(r);
      if (gaps_on) begin
         burst_left--;
         if (burst_left <= 0) begin
            pause_sender($urandom_range(1, MAX_SEND_GAP));
            burst_left = $urandom_range(1, 24);
         end
      end
   endtask

   task automatic wait_results_drained;
      if (req_valid) req_valid <= 1'b0;
      while (expected_verdicts.size() != 0) @(negedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_WIDTH-1:0] index,
                            logic [CSR_DATA_WIDTH-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= index;
      csr_wr_data <= value;
      case (index)
         CSR_STRIP_WIDTH:  cfg_width   = value;
         CSR_STRIP_HEIGHT: cfg_height  = value;
         CSR_PATTERN_ONLY: cfg_pattern = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic test_reset_defaults;
      rsp_pattern = RSP_RANDOM;
      send_fields(0, 0, 1, 0, 1'b0);
      send_fields(0, 0, 2, 0, 1'b1);
   endtask

   task automatic test_strip_bounds;
      wait_results_drained();
      write_csr(CSR_STRIP_WIDTH, 15'd100);
      write_csr(CSR_STRIP_HEIGHT, 15'd50);
      send_fields(0, 0, 100, 50, 1'b0);
      send_fields(1, 0, 100, 0, 1'b0);
      send_fields(0, 1, 0, 50, 1'b0);
      send_fields(-1, -1, 1, 1, 1'b0);
      send_fields(-32768, -32768, 0, 0, 1'b0);
      send_fields(32767, 32767, 32767, 32767, 1'b1);
   endtask

   task automatic test_overlap_scan;
      wait_results_drained();
      write_csr(CSR_STRIP_WIDTH, 15'd64);
      write_csr(CSR_STRIP_HEIGHT, 15'd64);
      rsp_pattern = RSP_PERIODIC;
      send_fields(0, 0, 10, 10, 1'b0);
      send_fields(10, 0, 10, 10, 1'b0);
      send_fields(0, 10, 10, 10, 1'b0);
      send_fields(9, 9, 2, 2, 1'b0);
      send_fields(15, 5, 1, 1, 1'b0);
      send_fields(5, 15, 0, 0, 1'b0);
      send_fields(40, 40, 5, 5, 1'b1);
   endtask

   task automatic test_pattern_only;
      wait_results_drained();
      write_csr(CSR_STRIP_WIDTH, 15'd10);
      write_csr(CSR_STRIP_HEIGHT, 15'd20);
      write_csr(CSR_PATTERN_ONLY, 15'd1);
      send_fields(0, 0, 5, 5, 1'b0);
      send_fields(0, 0, 5, 5, 1'b0);
      send_fields(-5, 0, 100, 20, 1'b0);
      send_fields(0, 19, 1, 2, 1'b1);
      wait_results_drained();
      write_csr(CSR_PATTERN_ONLY, 15'h7FFE);
      write_csr(CSR_UNUSED_INDEX, 15'h7FFF);
      send_fields(2, 2, 3, 3, 1'b1);
   endtask

   task automatic test_store_overflow;
      int i, x, y;
      wait_results_drained();
      write_csr(CSR_STRIP_WIDTH, 15'd32767);
      write_csr(CSR_STRIP_HEIGHT, 15'd8);
      rsp_pattern = RSP_RANDOM;
      for (i = 0; i <= STORE_DEPTH + 2; i++) begin
         x = i * 4;
         y = 0;
         if (i == 200) x = 13;
         if (i == STORE_DEPTH - 1) x = (STORE_DEPTH - 2) * 4 + 1;
         if (i >= STORE_DEPTH) x = 0;
         if (i == STORE_DEPTH + 1) y = -1;
         send_fields(x, y, 2, 1, i == STORE_DEPTH + 2);
      end
   endtask

   task automatic test_random_layouts;
      int phase, sent, len, k;
      for (phase = 0; phase < 6; phase++) begin
         wait_results_drained();
         case (phase)
            0: begin
               write_csr(CSR_STRIP_WIDTH, 15'd1);
               write_csr(CSR_STRIP_HEIGHT, 15'd0);
               write_csr(CSR_PATTERN_ONLY, 15'd0);
            end
            1: begin
               write_csr(CSR_STRIP_WIDTH, 15'd32767);
               write_csr(CSR_STRIP_HEIGHT, 15'd32767);
               write_csr(CSR_PATTERN_ONLY, 15'd1);
            end
            default: begin
               write_csr(CSR_STRIP_WIDTH, 15'($urandom_range(8, 300)));
               write_csr(CSR_STRIP_HEIGHT, 15'($urandom_range(4, 300)));
               write_csr(CSR_PATTERN_ONLY, 15'($urandom_range(0, 3) == 0));
            end
         endcase
         rsp_pattern = rsp_pattern_type'(phase % 4);
         gaps_on = (phase != 2);
         if (phase == 4) long_hold_armed = 1'b1;
         sent = 0;
         while (sent < 60) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                              : $urandom_range(1, 12);
            for (k = 0; k < len; k++) begin
               send_paced(random_rect(k == len - 1));
               sent++;
            end
         end
      end
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_reset_defaults();
      test_strip_bounds();
      test_overlap_scan();
      test_pattern_only();
      test_store_overflow();
      test_random_layouts();
      wait_results_drained();
      repeat (STORE_DEPTH + 8) @(negedge clock);
      if (mismatch_count == 0 && expected_verdicts.size() == 0) begin
         $display("packing_overlap_checker regression: pass");
      end else begin
         $display("packing_overlap_checker regression: fail");
      end
      $finish;
   end

endmodule
